@@ sv/wbss_pkg.sv @@
// ---------------------------------------------------------------------------
// wbss_pkg
// Shared widths, register indexes and reset values for the wildcard byte
// signature scan unit.
// ---------------------------------------------------------------------------
`default_nettype none

package wbss_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 48;

  // Signature storage: four 64-bit words of eight bytes each.
  localparam int unsigned SIG_BYTES  = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CARE_W     = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned PADDR_W    = 6;
  localparam int unsigned REG_IDX_W  = 3;

  // Register indexes, each register at byte address 8 * index.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_CARE_BITS      = 3'd4,
    REG_PATTERN_LENGTH = 3'd5
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [CARE_W-1:0] CARE_BITS_RESET      = '1;
  localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = 6'd1;

endpackage : wbss_pkg

`default_nettype wire

@@ sv/wbss_channels.sv @@
// ---------------------------------------------------------------------------
// wbss_in_if / wbss_out_if
// Valid/ready channels carrying scanned bytes in and match results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface wbss_in_if;
  logic                             valid;
  logic                             ready;
  logic [wbss_pkg::DATA_W-1:0]      data_byte;
  logic [wbss_pkg::ADDR_W-1:0]      byte_address;
  logic                             region_start;
  logic                             search_start;

  modport source (output valid, data_byte, byte_address, region_start, search_start,
                  input ready);
  modport sink   (input valid, data_byte, byte_address, region_start, search_start,
                  output ready);
endinterface : wbss_in_if

interface wbss_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [wbss_pkg::ADDR_W-1:0]      match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface : wbss_out_if

`default_nettype wire

@@ sv/wildcard_byte_signature_scan_unit.sv @@
// ---------------------------------------------------------------------------
// wildcard_byte_signature_scan_unit
// Scans a byte stream for a signature of up to 32 bytes with wildcard
// positions and reports the start address of the first match of a search.
// ---------------------------------------------------------------------------
// The unit takes one byte request per clock cycle while the skid register
// is empty and returns exactly one result for each. The window compare
// against all signature positions is a single parallel check between the
// state registers and the output registers. Results pass through a two-entry
// output buffer (result register plus skid register), so a request is still
// taken while one result waits to be collected; requests stop only when both
// entries are full. A match never spans a region and only the first match
// after a search start reports found, with match_address the address of the
// match's first byte (zero otherwise). The user writes configuration through
// the APB-style port only while the unit is idle; the block does not enforce
// it. Registers lie at byte address 8 * index and read back as written, the
// care bits and length keeping only their low 32 and 6 bits.
`default_nettype none

module wildcard_byte_signature_scan_unit #(
  parameter int unsigned PATTERN_MAX  = 32,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  wbss_in_if.sink                                  in_chan,
  wbss_out_if.source                               out_chan,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wbss_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [wbss_pkg::WORD_W-1:0]         pwdata,
  output logic      [wbss_pkg::WORD_W-1:0]         prdata,
  output logic                                     pready
);

  // Derived sizes.
  localparam int unsigned LEN_CAP = (PATTERN_MAX < wbss_pkg::SIG_BYTES) ?
                                    PATTERN_MAX : wbss_pkg::SIG_BYTES;
  localparam int unsigned IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CNT_W   = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CMP_W   = (CNT_W > wbss_pkg::LEN_W) ? CNT_W : wbss_pkg::LEN_W;
  localparam int unsigned AW      = (ADDRESS_BITS < wbss_pkg::ADDR_W) ?
                                    ADDRESS_BITS : wbss_pkg::ADDR_W;

  typedef logic [wbss_pkg::DATA_W-1:0] byte_t;

  // Configuration registers.
  logic [wbss_pkg::WORD_W-1:0] pattern_word [4];
  logic [wbss_pkg::CARE_W-1:0] care_bits;
  logic [wbss_pkg::LEN_W-1:0]  pattern_length;

  // Scan state.
  byte_t             window [PATTERN_MAX];
  logic [CNT_W-1:0]  bytes_in_region;
  logic              already_found;

  // Output buffer.
  logic                        out_valid;
  logic                        out_found;
  logic [wbss_pkg::ADDR_W-1:0] out_address;
  logic                        skid_valid;
  logic                        skid_found;
  logic [wbss_pkg::ADDR_W-1:0] skid_address;

  logic in_fire;
  logic out_fire;

  wbss_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign reg_idx   = wbss_pkg::reg_idx_t'(paddr[wbss_pkg::PADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < 4; w++) begin
        pattern_word[w] <= '0;
      end
      care_bits      <= wbss_pkg::CARE_BITS_RESET;
      pattern_length <= wbss_pkg::PATTERN_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        wbss_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= pwdata;
        wbss_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= pwdata;
        wbss_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= pwdata;
        wbss_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= pwdata;
        wbss_pkg::REG_CARE_BITS:      care_bits <= pwdata[wbss_pkg::CARE_W-1:0];
        wbss_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[wbss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      wbss_pkg::REG_PATTERN_WORD_0: prdata = pattern_word[0];
      wbss_pkg::REG_PATTERN_WORD_1: prdata = pattern_word[1];
      wbss_pkg::REG_PATTERN_WORD_2: prdata = pattern_word[2];
      wbss_pkg::REG_PATTERN_WORD_3: prdata = pattern_word[3];
      wbss_pkg::REG_CARE_BITS:
        prdata = {{(wbss_pkg::WORD_W - wbss_pkg::CARE_W){1'b0}}, care_bits};
      wbss_pkg::REG_PATTERN_LENGTH:
        prdata = {{(wbss_pkg::WORD_W - wbss_pkg::LEN_W){1'b0}}, pattern_length};
      default: prdata = '0;
    endcase
  end

  // Effective length: zero counts as one, capped by window and storage.
  logic [wbss_pkg::LEN_W-1:0] len_eff;

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = wbss_pkg::LEN_W'(1);
    end else if (pattern_length > wbss_pkg::LEN_W'(LEN_CAP)) begin
      len_eff = wbss_pkg::LEN_W'(LEN_CAP);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Window after the new byte is shifted in. Bytes older than the region
  // are never compared, because a match needs the region count to reach
  // the length, so the window needs no clearing.
  byte_t window_next [PATTERN_MAX];

  always_comb begin
    window_next[0] = in_chan.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // Region count after this byte, saturating at the window depth.
  logic [CNT_W-1:0] bytes_in_region_next;

  always_comb begin
    if (in_chan.region_start) begin
      bytes_in_region_next = CNT_W'(1);
    end else if (bytes_in_region < CNT_W'(PATTERN_MAX)) begin
      bytes_in_region_next = bytes_in_region + CNT_W'(1);
    end else begin
      bytes_in_region_next = bytes_in_region;
    end
  end

  // Parallel compare: signature byte j lines up with window slot len-1-j.
  logic [LEN_CAP-1:0] pos_mismatch;

  always_comb begin
    logic [wbss_pkg::LEN_W-1:0] pos;
    byte_t                      sig;
    for (int j = 0; j < LEN_CAP; j++) begin
      pos = len_eff - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(j);
      sig = pattern_word[j / 8][(j % 8) * 8 +: 8];
      pos_mismatch[j] = (wbss_pkg::LEN_W'(j) < len_eff) && care_bits[j] &&
                        (window_next[pos[IDX_W-1:0]] != sig);
    end
  end

  logic match;
  logic found_before;
  logic hit;
  logic [AW-1:0] start_address;
  logic [wbss_pkg::ADDR_W-1:0] result_address;

  assign match = (CMP_W'(bytes_in_region_next) >= CMP_W'(len_eff)) && (pos_mismatch == '0);
  assign found_before = already_found && !in_chan.search_start;
  assign hit = match && !found_before;
  assign start_address = in_chan.byte_address[AW-1:0] - AW'(len_eff) + AW'(1);
  assign result_address = hit ? wbss_pkg::ADDR_W'(start_address) : '0;

  // Handshakes.
  assign in_chan.ready = !skid_valid;
  assign in_fire       = in_chan.valid && !skid_valid;
  assign out_fire      = out_valid && out_chan.ready;

  // Scan state update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_region <= '0;
      already_found   <= 1'b0;
    end else if (in_fire) begin
      bytes_in_region <= bytes_in_region_next;
      already_found   <= found_before || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // Two-entry output buffer: the result register and a skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_found   <= skid_found;
        out_address <= skid_address;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_found   <= hit;
        out_address <= result_address;
      end else begin
        skid_found   <= hit;
        skid_address <= result_address;
      end
    end
  end

  assign out_chan.valid         = out_valid;
  assign out_chan.found         = out_found;
  assign out_chan.match_address = out_address;

endmodule : wildcard_byte_signature_scan_unit

`default_nettype wire
